@@ hw/rtl/lz11tp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lz11tp_pkg;

    localparam int GROUP     = 8;
    localparam int TOK_IDX_W = $clog2(GROUP);
    localparam int COUNT_W   = TOK_IDX_W + 1;

    localparam logic [7:0]  HDR_MAGIC = 8'h11;
    localparam logic [3:0]  BIG_TAG   = 4'h1;
    localparam logic [16:0] LEN_MIN   = 17'd3;
    localparam logic [16:0] LEN_MID   = 17'd17;
    localparam logic [16:0] LEN_BIG   = 17'd273;
    localparam logic [16:0] LEN_MAX   = 17'd65808;
    localparam logic [16:0] LEN_BIAS  = 17'd1;

    localparam logic CFG_PAD_GROUP = 1'b0;
    localparam logic CFG_ROUND     = 1'b1;

    typedef logic [TOK_IDX_W-1:0] t_tok_idx;
    typedef logic [1:0]           t_byte_idx;

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_LITERAL = 2'd1,
        KIND_MATCH   = 2'd2,
        KIND_FINISH  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_FLAG,
        ST_TOK,
        ST_GPAD,
        ST_ROUND,
        ST_BAD
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [23:0] total_length;
        logic [7:0]  literal_value;
        logic [16:0] match_length;
        logic [12:0] match_distance;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       bad_length;
    } t_out_item;

    typedef struct packed {
        logic        is_match;
        logic [16:0] length;
        logic [11:0] offset;
    } t_token;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       tok_last;
    } t_enc;

endpackage

`default_nettype wire

@@ hw/rtl/lz11tp_tok_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lz11tp_tok_mem (
    input  wire                  i_clk,
    input  wire                  i_we,
    input  lz11tp_pkg::t_tok_idx i_waddr,
    input  lz11tp_pkg::t_token   i_wdata,
    input  wire                  i_re,
    input  lz11tp_pkg::t_tok_idx i_raddr,
    output lz11tp_pkg::t_token   o_rdata
);
    import lz11tp_pkg::*;

    t_token r_mem [GROUP];
    t_token r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/lz11tp_tok_enc.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lz11tp_tok_enc (
    input  lz11tp_pkg::t_token    i_token,
    input  lz11tp_pkg::t_byte_idx i_bidx,
    output lz11tp_pkg::t_enc      o_enc
);
    import lz11tp_pkg::*;

    logic [16:0] w_base;
    logic [16:0] w_diff;
    logic [15:0] w_l;
    t_byte_idx   w_top;
    t_byte_idx   w_rem;

    always_comb begin
        if (i_token.length >= LEN_BIG) begin
            w_base = LEN_BIG;
            w_top  = 2'd3;
        end else if (i_token.length >= LEN_MID) begin
            w_base = LEN_MID;
            w_top  = 2'd2;
        end else begin
            w_base = LEN_BIAS;
            w_top  = 2'd1;
        end
        if (!i_token.is_match) begin
            w_top = 2'd0;
        end
        w_diff = i_token.length - w_base;
        w_l    = w_diff[15:0];
        w_rem  = w_top - i_bidx;

        o_enc.tok_last = (w_rem == 2'd0);
        case (w_rem)
            2'd0:    o_enc.out_byte = i_token.offset[7:0];
            2'd1:    o_enc.out_byte = {w_l[3:0], i_token.offset[11:8]};
            2'd2:    o_enc.out_byte = w_l[11:4];
            2'd3:    o_enc.out_byte = {BIG_TAG, w_l[15:12]};
            default: o_enc.out_byte = i_token.offset[7:0];
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/lz11_token_packer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake               | Payload
// input   | in        | i_in_valid / o_in_stall | i_in_data (t_in_item)
// output  | out       | o_out_valid/ i_out_stall| o_out_data (t_out_item)
// config  | in        | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One byte per cycle unless stalled, from a registered output stage; the byte sequencer sets pace.
// Start: accept + 4 header bytes; a token is buffered on accept; rejected match: one byte;
// a group flush: accept + flag byte + token bytes (1..4 each) + group padding + rounding.
// Synchronous reset clears the sequencer, token count, byte phase and config;
// the token buffer holds no defined value until written.
// i_out_stall holds the output stage and the sequencer; o_in_stall is high while busy.

module lz11_token_packer (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  lz11tp_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output lz11tp_pkg::t_out_item o_out_data,
    input  wire                   i_cfg_we,
    input  wire                   i_cfg_index,
    input  wire                   i_cfg_data
);
    import lz11tp_pkg::*;

    t_state       r_state, n_state;
    t_in_item     r_in, n_in;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_tidx, n_tidx;
    t_byte_idx    r_bidx, n_bidx;
    logic [1:0]   r_mod, n_mod;
    logic [7:0]   r_flags, n_flags;
    logic         r_pad, r_round;
    logic         r_out_valid, n_out_valid;
    t_out_item    r_out, n_out;

    logic         w_accept;
    logic         w_out_ready;
    logic         w_emit;
    logic [7:0]   w_byte;
    logic         w_last;
    logic         w_bad;
    logic         w_len_ok;
    logic         w_rnd_more;
    logic         w_is_fin;
    logic         w_tok_final;
    logic         mem_we;
    t_tok_idx     mem_waddr;
    t_token       mem_wdata;
    logic         mem_re;
    t_tok_idx     mem_raddr;
    t_token       mem_rdata;
    t_enc         w_enc;

    function automatic t_token make_token(input t_in_item item);
        t_token tok;
        logic [12:0] dm1;
        dm1 = item.match_distance - 13'd1;
        if (item.kind == KIND_MATCH) begin
            tok.is_match = 1'b1;
            tok.length   = item.match_length;
            tok.offset   = dm1[11:0];
        end else begin
            tok.is_match = 1'b0;
            tok.length   = '0;
            tok.offset   = {4'h0, item.literal_value};
        end
        return tok;
    endfunction

    lz11tp_tok_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    lz11tp_tok_enc u_enc (
        .i_token (mem_rdata),
        .i_bidx  (r_bidx),
        .o_enc   (w_enc)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_len_ok    = (i_in_data.match_length >= LEN_MIN) &&
                         (i_in_data.match_length <= LEN_MAX);
    assign w_is_fin    = (r_in.kind == KIND_FINISH);
    assign w_rnd_more  = w_is_fin && r_round && ((r_mod + 2'd1) != 2'd0);
    assign w_tok_final = (COUNT_W'(r_tidx + 1'b1) == r_count);

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_count     = r_count;
        n_tidx      = r_tidx;
        n_bidx      = r_bidx;
        n_mod       = r_mod;
        n_flags     = r_flags;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_emit      = 1'b0;
        w_byte      = 8'h00;
        w_last      = 1'b0;
        w_bad       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_count[TOK_IDX_W-1:0];
        mem_wdata   = make_token(i_in_data);
        mem_re      = 1'b0;
        mem_raddr   = TOK_IDX_W'(r_tidx + 1'b1);

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_in = i_in_data;
                    case (i_in_data.kind)
                        KIND_START: begin
                            n_count = '0;
                            n_mod   = '0;
                            n_bidx  = '0;
                            n_state = ST_HDR;
                        end
                        KIND_LITERAL, KIND_MATCH: begin
                            if (i_in_data.kind == KIND_MATCH && !w_len_ok) begin
                                n_state = ST_BAD;
                            end else if (r_count == COUNT_W'(GROUP)) begin
                                n_state = ST_FLAG;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                                if (r_count == '0) begin
                                    n_flags = {mem_wdata.is_match, 7'b0};
                                end else begin
                                    n_flags[~r_count[TOK_IDX_W-1:0]] = mem_wdata.is_match;
                                end
                            end
                        end
                        KIND_FINISH: begin
                            if (r_count != '0) begin
                                n_state = ST_FLAG;
                            end else if (r_round && r_mod != 2'd0) begin
                                n_state = ST_ROUND;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_HDR: begin
                if (w_out_ready) begin
                    w_emit = 1'b1;
                    case (r_bidx)
                        2'd0:    w_byte = HDR_MAGIC;
                        2'd1:    w_byte = r_in.total_length[7:0];
                        2'd2:    w_byte = r_in.total_length[15:8];
                        2'd3:    w_byte = r_in.total_length[23:16];
                        default: w_byte = HDR_MAGIC;
                    endcase
                    w_last = (r_bidx == 2'd3);
                    n_mod  = r_mod + 2'd1;
                    n_bidx = r_bidx + 2'd1;
                    if (r_bidx == 2'd3) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FLAG: begin
                if (w_out_ready) begin
                    w_emit    = 1'b1;
                    w_byte    = r_flags;
                    n_mod     = r_mod + 2'd1;
                    mem_re    = 1'b1;
                    mem_raddr = '0;
                    n_tidx    = '0;
                    n_bidx    = '0;
                    n_state   = ST_TOK;
                end
            end
            ST_TOK: begin
                if (w_out_ready) begin
                    w_emit = 1'b1;
                    w_byte = w_enc.out_byte;
                    n_mod  = r_mod + 2'd1;
                    if (!w_enc.tok_last) begin
                        n_bidx = r_bidx + 2'd1;
                    end else if (!w_tok_final) begin
                        mem_re = 1'b1;
                        n_tidx = r_tidx + 1'b1;
                        n_bidx = '0;
                    end else begin
                        n_count = '0;
                        n_tidx  = r_tidx + 1'b1;
                        if (w_is_fin) begin
                            if (r_pad && r_count != COUNT_W'(GROUP)) begin
                                n_state = ST_GPAD;
                            end else if (w_rnd_more) begin
                                n_state = ST_ROUND;
                            end else begin
                                n_state = ST_IDLE;
                            end
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = make_token(r_in);
                            n_count   = COUNT_W'(1);
                            n_flags   = {mem_wdata.is_match, 7'b0};
                            n_state   = ST_IDLE;
                        end
                    end
                    w_last = w_enc.tok_last && w_tok_final && !w_rnd_more &&
                             !(w_is_fin && r_pad && r_count != COUNT_W'(GROUP));
                end
            end
            ST_GPAD: begin
                if (w_out_ready) begin
                    w_emit = 1'b1;
                    n_mod  = r_mod + 2'd1;
                    n_tidx = r_tidx + 1'b1;
                    w_last = (r_tidx == COUNT_W'(GROUP - 1)) && !w_rnd_more;
                    if (r_tidx == COUNT_W'(GROUP - 1)) begin
                        n_state = w_rnd_more ? ST_ROUND : ST_IDLE;
                    end
                end
            end
            ST_ROUND: begin
                if (w_out_ready) begin
                    w_emit = 1'b1;
                    n_mod  = r_mod + 2'd1;
                    w_last = ((r_mod + 2'd1) == 2'd0);
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_BAD: begin
                if (w_out_ready) begin
                    w_emit  = 1'b1;
                    w_last  = 1'b1;
                    w_bad   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (w_emit) begin
            n_out_valid      = 1'b1;
            n_out.out_byte   = w_byte;
            n_out.last       = w_last;
            n_out.bad_length = w_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_tidx      <= '0;
            r_bidx      <= '0;
            r_mod       <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_tidx      <= n_tidx;
            r_bidx      <= n_bidx;
            r_mod       <= n_mod;
            r_flags     <= n_flags;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad   <= 1'b0;
            r_round <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAD_GROUP: r_pad   <= i_cfg_data;
                CFG_ROUND:     r_round <= i_cfg_data;
                default:       r_pad   <= r_pad;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
